// ===== rtl/core/sample_op_chain_macros.svh =====
// assertion macros shared by the sample op chain rtl
`ifndef SAMPLE_OP_CHAIN_MACROS_SVH
`define SAMPLE_OP_CHAIN_MACROS_SVH

// concurrent assertion clocked on the rising edge, off during reset
`define SOC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("sample op chain assertion failed");

// same-cycle implication clocked on the rising edge, off during reset
`define SOC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("sample op chain implication failed");

`endif

// ===== rtl/core/soc_pkg.sv =====
// types and constants of the sample op chain
`default_nettype none
package soc_pkg;

  localparam int DATA_W    = 32;
  localparam int SMP_W     = 16;
  localparam int WORD_W    = 34;
  localparam int DIV_STEPS = DATA_W;
  localparam int STAGE_LAT = DIV_STEPS + 2;

  // configuration register indexes
  localparam logic [1:0] CFG_STAGE_COUNT = 2'd0;
  localparam logic [1:0] CFG_TABLE_INDEX = 2'd1;
  localparam logic [1:0] CFG_TABLE_WORD  = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  // running value between table stages
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              fault;
  } smp_t;

  // per stage program
  typedef struct packed {
    op_e               op;
    logic [DATA_W-1:0] operand;
    logic              en;
  } stg_cfg_t;

  // divider work word
  typedef struct packed {
    logic              isdiv;
    logic              neg;
    logic              fault;
    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] mb;
  } dv_t;

endpackage
`default_nettype wire

// ===== rtl/core/soc_stage.sv =====
// one pipelined table stage: add, sub, mul or bit-serial pipelined divide
`default_nettype none
`include "sample_op_chain_macros.svh"
module soc_stage
  import soc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire stg_cfg_t cfg_i,
  input  wire logic     valid_i,
  input  wire smp_t     data_i,
  output logic          valid_o,
  output smp_t          data_o
);

  dv_t  prep_d;
  dv_t  p_q [DIV_STEPS+1];
  logic pv_q [DIV_STEPS+1];
  smp_t out_q;
  logic out_v_q;
  dv_t  last_w;
  logic last_v;
  logic fault_src;

  // prep: add, sub, mul finish here; divide gets magnitudes or special result
  always_comb begin
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    a = data_i.value;
    b = cfg_i.operand;
    prep_d       = '0;
    prep_d.fault = data_i.fault;
    prep_d.acc   = a;
    prep_d.mb    = {{(DATA_W-1){1'b0}}, 1'b1};
    if (cfg_i.en) begin
      case (cfg_i.op)
        OP_ADD: prep_d.acc = a + b;
        OP_SUB: prep_d.acc = a - b;
        OP_MUL: prep_d.acc = a * b;
        OP_DIV: begin
          if (b == '0) begin
            prep_d.fault = 1'b1;
            if (a == '0) begin
              prep_d.acc = '0;
            end else if (a[DATA_W-1]) begin
              prep_d.acc = {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
              prep_d.acc = {1'b0, {(DATA_W-1){1'b1}}};
            end
          end else if (a == {1'b1, {(DATA_W-1){1'b0}}} && b == '1) begin
            prep_d.fault = 1'b1;
            prep_d.acc   = a;
          end else begin
            prep_d.isdiv = 1'b1;
            prep_d.neg   = a[DATA_W-1] ^ b[DATA_W-1];
            prep_d.acc   = a[DATA_W-1] ? (~a + 1'b1) : a;
            prep_d.mb    = b[DATA_W-1] ? (~b + 1'b1) : b;
          end
        end
        default: prep_d.acc = a;
      endcase
    end
  end

  // prep register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q[0] <= 1'b0;
    end else begin
      pv_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q[0] <= prep_d;
  end

  // one restoring quotient bit per pipeline step
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    dv_t          step_d;
    logic [DATA_W:0] trial;

    always_comb begin
      step_d = p_q[k];
      trial  = {p_q[k].rem, p_q[k].acc[DATA_W-1]};
      if (p_q[k].isdiv) begin
        if (trial >= {1'b0, p_q[k].mb}) begin
          step_d.rem = DATA_W'(trial - {1'b0, p_q[k].mb});
          step_d.acc = {p_q[k].acc[DATA_W-2:0], 1'b1};
        end else begin
          step_d.rem = trial[DATA_W-1:0];
          step_d.acc = {p_q[k].acc[DATA_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pv_q[k+1] <= 1'b0;
      end else begin
        pv_q[k+1] <= pv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      p_q[k+1] <= step_d;
    end
  end

  // sign fixup of the quotient
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= pv_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q.fault <= p_q[DIV_STEPS].fault;
    if (p_q[DIV_STEPS].isdiv && p_q[DIV_STEPS].neg) begin
      out_q.value <= ~p_q[DIV_STEPS].acc + 1'b1;
    end else begin
      out_q.value <= p_q[DIV_STEPS].acc;
    end
  end

  assign valid_o = out_v_q;
  assign data_o  = out_q;

  // short names for the checks
  assign last_w    = p_q[DIV_STEPS];
  assign last_v    = pv_q[DIV_STEPS];
  assign fault_src = data_i.fault || (cfg_i.en && cfg_i.op == OP_DIV);

  `SOC_ASSERT(a_div_nonzero, clk_i, rst_ni, (pv_q[0] && p_q[0].isdiv) |-> (p_q[0].mb != '0))
  `SOC_ASSERT_IMP(a_rem_below, clk_i, rst_ni, last_v && last_w.isdiv, last_w.rem < last_w.mb)
  `SOC_ASSERT_IMP(a_fault_src, clk_i, rst_ni, pv_q[0] && p_q[0].fault, $past(fault_src))

endmodule
`default_nettype wire

// ===== rtl/core/sample_op_chain.sv =====
// A sample passes the input register, all MAX_STAGES table stages and the result register, for any stage_count.
// Throughput: one sample per cycle; each table stage is a 34-deep pipeline
// (prep with add/sub/mul, 32 one-bit divide steps, sign fixup).
// busy stays low and cfg_ready_o high; results cannot be stalled.
// Reset clears the pipeline valid bits, stage_count, table_index and the table.
`default_nettype none
module sample_op_chain
  import soc_pkg::*;
#(
  parameter int MAX_STAGES = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic signed [15:0] sample_in_i,
  output logic                   done_o,
  output logic signed [15:0]     sample_out_o,
  output logic                   div_fault_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [33:0]       cfg_data_i
);

  logic [4:0]        stage_count_q;
  logic [3:0]        table_index_q;
  logic [WORD_W-1:0] table_q [MAX_STAGES];
  logic              cfg_we;
  logic              in_v_q;
  smp_t              in_q;
  logic              sv [MAX_STAGES+1];
  smp_t              sd [MAX_STAGES+1];
  logic              done_q;
  logic [SMP_W-1:0]  out_q;
  logic              fault_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_count_q <= '0;
      table_index_q <= '0;
    end else if (cfg_we) begin
      if (cfg_index_i == CFG_STAGE_COUNT) begin
        stage_count_q <= cfg_data_i[4:0];
      end
      if (cfg_index_i == CFG_TABLE_INDEX) begin
        table_index_q <= cfg_data_i[3:0];
      end
    end
  end

  // op table, one entry per stage
  for (genvar i = 0; i < MAX_STAGES; i++) begin : g_tbl
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        table_q[i] <= '0;
      end else if (cfg_we && cfg_index_i == CFG_TABLE_WORD &&
                   32'(table_index_q) == 32'(i)) begin
        table_q[i] <= cfg_data_i;
      end
    end
  end

  // input register with sign extension
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q.value <= {{(DATA_W-SMP_W){sample_in_i[SMP_W-1]}}, sample_in_i};
    in_q.fault <= 1'b0;
  end

  assign sv[0] = in_v_q;
  assign sd[0] = in_q;

  // stage chain
  for (genvar i = 0; i < MAX_STAGES; i++) begin : g_stage
    stg_cfg_t scfg;
    assign scfg.op      = op_e'(table_q[i][WORD_W-1:DATA_W]);
    assign scfg.operand = table_q[i][DATA_W-1:0];
    assign scfg.en      = 32'(i) < 32'(stage_count_q);

    soc_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cfg_i   (scfg),
      .valid_i (sv[i]),
      .data_i  (sd[i]),
      .valid_o (sv[i+1]),
      .data_o  (sd[i+1])
    );
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= sv[MAX_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= sd[MAX_STAGES].value[SMP_W-1:0];
    fault_q <= sd[MAX_STAGES].fault;
  end

  assign done_o       = done_q;
  assign sample_out_o = out_q;
  assign div_fault_o  = fault_q;

endmodule
`default_nettype wire
